FILE: sv/jddm_pkg.sv
// Shared constants and elaboration-time helpers for the joystick drive mixer.
package jddm_pkg;

  localparam int IN_W     = 7;     // raw stick axis width
  localparam int CMP_W    = 10;    // PWM compare field width
  localparam int RAD_FRAC = 8;     // fraction bits of the radius
  localparam int PWR_MID  = 500;   // power at rest
  localparam int PWR_MAX  = 1000;  // full-scale power
  localparam int S_DATA_W = 16;    // input beat: two axes, padded to bytes
  localparam int M_DATA_W = 24;    // output beat: two wheels, padded to bytes
  localparam int M_PAD_W  = M_DATA_W - 2 * (CMP_W + 1);

  // Integer square root, digit by digit; only evaluated at elaboration.
  function automatic longint unsigned isqrt_c(longint unsigned x);
    longint unsigned rem_v;
    longint unsigned res_v;
    longint unsigned bit_v;
    rem_v = x;
    res_v = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > rem_v) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (rem_v >= res_v + bit_v) begin
        rem_v = rem_v - (res_v + bit_v);
        res_v = (res_v >> 1) + bit_v;
      end else begin
        res_v = res_v >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res_v;
  endfunction

endpackage

FILE: sv/jddm_sqrt_cell.sv
// One root-bit cell of the pipelined square-root chain.
module jddm_sqrt_cell #(
  parameter int RADW    = 32,
  parameter int BIT_POS = 30,
  parameter int SBW     = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  logic [RADW-1:0] x_i,
  input  logic [RADW-1:0] res_i,
  input  logic [SBW-1:0]  sb_i,
  output logic            vld_o,
  output logic [RADW-1:0] x_o,
  output logic [RADW-1:0] res_o,
  output logic [SBW-1:0]  sb_o
);

  localparam logic [RADW-1:0] BIT_V = RADW'(1) << BIT_POS;

  logic            vld_q;
  logic [RADW-1:0] x_q, x_d;
  logic [RADW-1:0] res_q, res_d;
  logic [SBW-1:0]  sb_q;
  logic [RADW-1:0] trial;

  always_comb begin
    trial = res_i + BIT_V;
    if (x_i >= trial) begin
      x_d   = x_i - trial;
      res_d = (res_i >> 1) + BIT_V;
    end else begin
      x_d   = x_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q   <= x_d;
      res_q <= res_d;
      sb_q  <= sb_i;
    end
  end

  assign vld_o = vld_q;
  assign x_o   = x_q;
  assign res_o = res_q;
  assign sb_o  = sb_q;

endmodule

FILE: sv/jddm_div_cell.sv
// One quotient-bit cell of the two-lane restoring divider chain.
module jddm_div_cell #(
  parameter int CW    = 44,
  parameter int QW    = 26,
  parameter int RTW   = 16,
  parameter int SHIFT = 25
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  logic [CW-1:0]  rem_r_i,
  input  logic [CW-1:0]  rem_l_i,
  input  logic [QW-1:0]  quo_r_i,
  input  logic [QW-1:0]  quo_l_i,
  input  logic [RTW-1:0] dvs_i,
  input  logic [1:0]     neg_i,
  output logic           vld_o,
  output logic [CW-1:0]  rem_r_o,
  output logic [CW-1:0]  rem_l_o,
  output logic [QW-1:0]  quo_r_o,
  output logic [QW-1:0]  quo_l_o,
  output logic [RTW-1:0] dvs_o,
  output logic [1:0]     neg_o
);

  logic           vld_q;
  logic [CW-1:0]  rem_r_q, rem_l_q;
  logic [QW-1:0]  quo_r_q, quo_l_q;
  logic [RTW-1:0] dvs_q;
  logic [1:0]     neg_q;
  logic [CW-1:0]  dv_sh;
  logic           ge_r, ge_l;

  assign dv_sh = CW'(dvs_i) << SHIFT;
  assign ge_r  = rem_r_i >= dv_sh;
  assign ge_l  = rem_l_i >= dv_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_r_q <= ge_r ? rem_r_i - dv_sh : rem_r_i;
      rem_l_q <= ge_l ? rem_l_i - dv_sh : rem_l_i;
      quo_r_q <= {quo_r_i[QW-2:0], ge_r};
      quo_l_q <= {quo_l_i[QW-2:0], ge_l};
      dvs_q   <= dvs_i;
      neg_q   <= neg_i;
    end
  end

  assign vld_o   = vld_q;
  assign rem_r_o = rem_r_q;
  assign rem_l_o = rem_l_q;
  assign quo_r_o = quo_r_q;
  assign quo_l_o = quo_l_q;
  assign dvs_o   = dvs_q;
  assign neg_o   = neg_q;

endmodule

FILE: sv/joystick_differential_drive_mixer.sv
// Top level: stick sample in, PWM compare and direction for both wheels out.
// Usage
//   Input stream (s_axis_*): one beat per stick sample, both raw axes in tdata.
//   Output stream (m_axis_*): one beat per sample, compare value and reverse
//   bit for the right and the left wheel.
//   cfg_we_i/cfg_wdata_i write the mirror bit (flips the mix sign on both
//   wheels); write it only while no sample is in flight.
// Pipeline and throughput
//   A sample enters every clock while the pipeline advances (see Stall). A
//   sample passes through two entry stages, a square-root chain of RTW cells
//   (one root bit per cell), three mixing stages, a divider chain of
//   QW = FRAC_BITS + 10 cells (one quotient bit per cell) and the output
//   register.
// Reset
//   rst_ni clears all valid flags and the mirror bit; the pipeline comes up
//   empty and ready.
// Stall
//   The pipeline keeps moving while its last stage is empty, so new beats are
//   taken while a finished result waits in the output register. It freezes as
//   a whole only when both the output register and the last cell hold results.
module joystick_differential_drive_mixer #(
  parameter int STICK_CENTER = 64,
  parameter int FRAC_BITS    = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [6:0] stick_horizontal, [13:7] stick_vertical, [15:14] zero
  input  logic [jddm_pkg::S_DATA_W-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [9:0] right_compare, [10] right_reverse, [20:11] left_compare,
  // [21] left_reverse, [23:22] zero
  output logic [jddm_pkg::M_DATA_W-1:0] m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i
);

  import jddm_pkg::*;

  // ---------------------------------------------------------------------------
  // Derived sizes
  // ---------------------------------------------------------------------------
  localparam int RAW_MAX = (1 << IN_W) - 1;
  localparam int MAXABS  = (STICK_CENTER > RAW_MAX - STICK_CENTER) ?
                           STICK_CENTER : RAW_MAX - STICK_CENTER;
  localparam int HW      = $clog2(MAXABS + 1) + 1;          // signed axis width
  localparam int SW2     = 2 * HW + 1;
  localparam longint unsigned SPAN    = 2 * longint'(STICK_CENTER);
  localparam longint unsigned SPAN_SQ = SPAN * SPAN;
  localparam longint unsigned SQ_MAX  = 2 * longint'(MAXABS) * longint'(MAXABS);
  localparam longint unsigned S_MAX   = (SQ_MAX > SPAN_SQ) ? SQ_MAX : SPAN_SQ;
  localparam int SQW      = $clog2(S_MAX + 1);
  localparam int RADW_RAW = SQW + 2 * RAD_FRAC;
  localparam int RADW     = RADW_RAW + (RADW_RAW % 2);      // radicand, even
  localparam int RTW      = RADW / 2;                       // root bits = cells
  localparam int SBW      = 2 * HW;
  localparam longint unsigned K_RT2 = isqrt_c(64'd1 << (2 * FRAC_BITS - 1));
  localparam longint unsigned K_035 = (35 * (64'd1 << FRAC_BITS) + 50) / 100;
  localparam int KW   = FRAC_BITS + 1;
  localparam int PW   = HW + 1 + KW;                        // product width
  localparam int NMW  = PW + 10;                            // mix * 500
  localparam int QW   = FRAC_BITS + 10;                     // |quotient| < 1024.0
  localparam int CW   = (NMW + RAD_FRAC > RTW + QW) ? NMW + RAD_FRAC : RTW + QW;
  localparam int PWW  = QW + 2;

  localparam logic signed [HW-1:0]  CTR_V     = HW'(STICK_CENTER);
  localparam logic        [SQW-1:0] SPAN_SQ_V = SQW'(SPAN_SQ);
  localparam logic signed [PW-1:0]  KRT2_P    = PW'(K_RT2);
  localparam logic signed [PW-1:0]  K035_P    = PW'(K_035);
  localparam logic signed [PWW-1:0] BASE_P    = PWW'(longint'(PWR_MID) << FRAC_BITS);
  localparam logic signed [PWW-1:0] TOP_P     = PWW'(longint'(PWR_MAX) << FRAC_BITS);

  // ---------------------------------------------------------------------------
  // Flow control
  // ---------------------------------------------------------------------------
  logic              adv;
  logic              mirror_q;
  logic              out_vld_q;
  logic [CMP_W-1:0]  r_cmp_q, l_cmp_q;
  logic              r_rev_q, l_rev_q;

  logic [QW:0]       dv_vld;

  assign adv           = !dv_vld[QW] || !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  // ---------------------------------------------------------------------------
  // Stage 1: center the axes
  // ---------------------------------------------------------------------------
  logic signed [HW-1:0] in_h, in_v;
  logic                 s1_vld_q;
  logic signed [HW-1:0] s1_h_q, s1_v_q;

  assign in_h = $signed({{(HW - IN_W){1'b0}}, s_axis_tdata[IN_W-1:0]}) - CTR_V;
  assign in_v = $signed({{(HW - IN_W){1'b0}}, s_axis_tdata[2*IN_W-1:IN_W]}) - CTR_V;

  // ---------------------------------------------------------------------------
  // Stage 2: radius squared, floored at the full-deflection span squared, in Q.16
  // ---------------------------------------------------------------------------
  logic signed [SW2-1:0] h_x, v_x, sq_sum;
  logic [SQW-1:0]        s_w, s_eff;
  logic                  s2_vld_q;
  logic [RADW-1:0]       s2_rad_q;
  logic signed [HW-1:0]  s2_h_q, s2_v_q;

  assign h_x    = SW2'(s1_h_q);
  assign v_x    = SW2'(s1_v_q);
  assign sq_sum = h_x * h_x + v_x * v_x;
  assign s_w    = sq_sum[SQW-1:0];
  assign s_eff  = (s_w > SPAN_SQ_V) ? s_w : SPAN_SQ_V;

  // ---------------------------------------------------------------------------
  // Square-root chain: divisor D in Q.8
  // ---------------------------------------------------------------------------
  logic [RTW:0]                sq_vld;
  logic [RTW-1:0][RADW-1:0]    sq_x;
  logic [RTW:0][RADW-1:0]      sq_res;
  logic [RTW:0][SBW-1:0]       sq_sb;

  assign sq_vld[0] = s2_vld_q;
  assign sq_x[0]   = s2_rad_q;
  assign sq_res[0] = '0;
  assign sq_sb[0]  = {s2_v_q, s2_h_q};

  for (genvar k = 0; k < RTW; k++) begin : g_sqrt
    if (k < RTW - 1) begin : g_mid
      jddm_sqrt_cell #(
        .RADW    (RADW),
        .BIT_POS (2 * (RTW - 1 - k)),
        .SBW     (SBW)
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (adv),
        .vld_i  (sq_vld[k]),
        .x_i    (sq_x[k]),
        .res_i  (sq_res[k]),
        .sb_i   (sq_sb[k]),
        .vld_o  (sq_vld[k+1]),
        .x_o    (sq_x[k+1]),
        .res_o  (sq_res[k+1]),
        .sb_o   (sq_sb[k+1])
      );
    end else begin : g_last
      jddm_sqrt_cell #(
        .RADW    (RADW),
        .BIT_POS (2 * (RTW - 1 - k)),
        .SBW     (SBW)
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (adv),
        .vld_i  (sq_vld[k]),
        .x_i    (sq_x[k]),
        .res_i  (sq_res[k]),
        .sb_i   (sq_sb[k]),
        .vld_o  (sq_vld[k+1]),
        .x_o    (),
        .res_o  (sq_res[k+1]),
        .sb_o   (sq_sb[k+1])
      );
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: mix products, sum term and difference term times 1/sqrt2,
  // horizontal term times 0.35
  // ---------------------------------------------------------------------------
  logic signed [HW-1:0] sb_h, sb_v;
  logic signed [PW-1:0] hs, dvh, hx;
  logic                 s3_vld_q;
  logic signed [PW-1:0] s3_pa_q, s3_pb_q, s3_pc_q;
  logic [RTW-1:0]       s3_dq_q;

  assign sb_h = $signed(sq_sb[RTW][HW-1:0]);
  assign sb_v = $signed(sq_sb[RTW][2*HW-1:HW]);
  assign hs   = PW'(sb_h) + PW'(sb_v);
  assign dvh  = PW'(sb_v) - PW'(sb_h);
  assign hx   = PW'(sb_h);

  // ---------------------------------------------------------------------------
  // Stage 4: X_R, X_L, times 500 (512 - 8 - 4)
  // ---------------------------------------------------------------------------
  logic signed [NMW-1:0] xr, xl, nr, nl;
  logic                  s4_vld_q;
  logic signed [NMW-1:0] s4_nr_q, s4_nl_q;
  logic [RTW-1:0]        s4_dq_q;

  assign xr = NMW'(s3_pb_q) - NMW'(s3_pa_q);
  assign xl = NMW'(s3_pc_q) + NMW'(s3_pb_q);
  assign nr = (xr <<< 9) - (xr <<< 3) - (xr <<< 2);
  assign nl = (xl <<< 9) - (xl <<< 3) - (xl <<< 2);

  // ---------------------------------------------------------------------------
  // Stage 5: sign and magnitude, scaled by 2^8 for the Q.8 divisor
  // ---------------------------------------------------------------------------
  logic [NMW-1:0] mag_r, mag_l;
  logic           s5_vld_q;
  logic [CW-1:0]  s5_rem_r_q, s5_rem_l_q;
  logic [1:0]     s5_neg_q;
  logic [RTW-1:0] s5_dq_q;

  assign mag_r = s4_nr_q[NMW-1] ? $unsigned(-s4_nr_q) : $unsigned(s4_nr_q);
  assign mag_l = s4_nl_q[NMW-1] ? $unsigned(-s4_nl_q) : $unsigned(s4_nl_q);

  // ---------------------------------------------------------------------------
  // Divider chain: both wheels share the divisor, truncating quotient
  // ---------------------------------------------------------------------------
  logic [QW-1:0][CW-1:0]  dv_rem_r, dv_rem_l;
  logic [QW:0][QW-1:0]    dv_quo_r, dv_quo_l;
  logic [QW:0][RTW-1:0]   dv_dq;
  logic [QW:0][1:0]       dv_neg;

  assign dv_vld[0]   = s5_vld_q;
  assign dv_rem_r[0] = s5_rem_r_q;
  assign dv_rem_l[0] = s5_rem_l_q;
  assign dv_quo_r[0] = '0;
  assign dv_quo_l[0] = '0;
  assign dv_dq[0]    = s5_dq_q;
  assign dv_neg[0]   = s5_neg_q;

  for (genvar j = 0; j < QW; j++) begin : g_div
    if (j < QW - 1) begin : g_mid
      jddm_div_cell #(
        .CW    (CW),
        .QW    (QW),
        .RTW   (RTW),
        .SHIFT (QW - 1 - j)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (adv),
        .vld_i   (dv_vld[j]),
        .rem_r_i (dv_rem_r[j]),
        .rem_l_i (dv_rem_l[j]),
        .quo_r_i (dv_quo_r[j]),
        .quo_l_i (dv_quo_l[j]),
        .dvs_i   (dv_dq[j]),
        .neg_i   (dv_neg[j]),
        .vld_o   (dv_vld[j+1]),
        .rem_r_o (dv_rem_r[j+1]),
        .rem_l_o (dv_rem_l[j+1]),
        .quo_r_o (dv_quo_r[j+1]),
        .quo_l_o (dv_quo_l[j+1]),
        .dvs_o   (dv_dq[j+1]),
        .neg_o   (dv_neg[j+1])
      );
    end else begin : g_last
      jddm_div_cell #(
        .CW    (CW),
        .QW    (QW),
        .RTW   (RTW),
        .SHIFT (QW - 1 - j)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (adv),
        .vld_i   (dv_vld[j]),
        .rem_r_i (dv_rem_r[j]),
        .rem_l_i (dv_rem_l[j]),
        .quo_r_i (dv_quo_r[j]),
        .quo_l_i (dv_quo_l[j]),
        .dvs_i   (dv_dq[j]),
        .neg_i   (dv_neg[j]),
        .vld_o   (dv_vld[j+1]),
        .rem_r_o (),
        .rem_l_o (),
        .quo_r_o (dv_quo_r[j+1]),
        .quo_l_o (dv_quo_l[j+1]),
        .dvs_o   (dv_dq[j+1]),
        .neg_o   (dv_neg[j+1])
      );
    end
  end

  // ---------------------------------------------------------------------------
  // Output: 500 +/- quotient, clamp, drop fraction, compare and direction
  // ---------------------------------------------------------------------------
  // Returns {reverse, compare}.
  function automatic logic [CMP_W:0] to_pwm(logic [QW-1:0] q, logic add);
    logic signed [PWW-1:0] pw;
    logic [CMP_W-1:0]      p;
    logic [CMP_W:0]        two_p;
    pw = add ? BASE_P + $signed(PWW'(q)) : BASE_P - $signed(PWW'(q));
    if (pw < 0) begin
      p = '0;
    end else if (pw > TOP_P) begin
      p = CMP_W'(PWR_MAX);
    end else begin
      p = CMP_W'(pw >>> FRAC_BITS);
    end
    two_p = {p, 1'b0};
    if (p > CMP_W'(PWR_MID)) begin
      return {1'b1, CMP_W'(two_p - (CMP_W + 1)'(PWR_MAX))};
    end else begin
      return {1'b0, CMP_W'((CMP_W + 1)'(PWR_MAX) - two_p)};
    end
  endfunction

  logic           add_r, add_l;
  logic [CMP_W:0] pwm_r, pwm_l;

  // Normal: right subtracts its quotient, left adds; mirror flips both.
  assign add_r = mirror_q != dv_neg[QW][0];
  assign add_l = mirror_q == dv_neg[QW][1];
  assign pwm_r = to_pwm(dv_quo_r[QW], add_r);
  assign pwm_l = to_pwm(dv_quo_l[QW], add_l);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mirror_q  <= 1'b0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mirror_q <= cfg_wdata_i;
      end
      if (adv) begin
        s1_vld_q <= s_axis_tvalid;
        s2_vld_q <= s1_vld_q;
        s3_vld_q <= sq_vld[RTW];
        s4_vld_q <= s3_vld_q;
        s5_vld_q <= s4_vld_q;
      end
      if (!out_vld_q || m_axis_tready) begin
        out_vld_q <= dv_vld[QW];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_h_q     <= in_h;
      s1_v_q     <= in_v;
      s2_rad_q   <= RADW'({s_eff, {(2 * RAD_FRAC){1'b0}}});
      s2_h_q     <= s1_h_q;
      s2_v_q     <= s1_v_q;
      s3_pa_q    <= hs * KRT2_P;
      s3_pb_q    <= hx * K035_P;
      s3_pc_q    <= dvh * KRT2_P;
      s3_dq_q    <= sq_res[RTW][RTW-1:0];
      s4_nr_q    <= nr;
      s4_nl_q    <= nl;
      s4_dq_q    <= s3_dq_q;
      s5_rem_r_q <= CW'({mag_r, {RAD_FRAC{1'b0}}});
      s5_rem_l_q <= CW'({mag_l, {RAD_FRAC{1'b0}}});
      s5_neg_q   <= {s4_nl_q[NMW-1], s4_nr_q[NMW-1]};
      s5_dq_q    <= s4_dq_q;
    end
    if (!out_vld_q || m_axis_tready) begin
      r_cmp_q <= pwm_r[CMP_W-1:0];
      r_rev_q <= pwm_r[CMP_W];
      l_cmp_q <= pwm_l[CMP_W-1:0];
      l_rev_q <= pwm_l[CMP_W];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{M_PAD_W{1'b0}}, l_rev_q, l_cmp_q, r_rev_q, r_cmp_q};

endmodule

FILE: sv/jddm_check.sv
// Port-level checker for the drive mixer, bound to the top level.
module jddm_check (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [jddm_pkg::M_DATA_W-1:0] m_axis_tdata
);

  import jddm_pkg::*;

  logic [CMP_W-1:0]   rc, lc;
  logic               rr, lr;
  logic [M_PAD_W-1:0] pad;

  assign rc  = m_axis_tdata[CMP_W-1:0];
  assign rr  = m_axis_tdata[CMP_W];
  assign lc  = m_axis_tdata[2*CMP_W:CMP_W+1];
  assign lr  = m_axis_tdata[2*CMP_W+1];
  assign pad = m_axis_tdata[M_DATA_W-1:2*CMP_W+2];

  // Stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // Compare is |2p - 1000|: even and within full scale.
  a_cmp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> rc <= CMP_W'(PWR_MAX) && lc <= CMP_W'(PWR_MAX) && !rc[0] && !lc[0])
    else $error("compare value out of range or odd");

  // Reverse means power above mid, so compare cannot be zero.
  a_rev_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!rr || rc != '0) && (!lr || lc != '0))
    else $error("reverse set with zero compare");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pad == '0)
    else $error("pad bits of result beat not zero");

endmodule

bind joystick_differential_drive_mixer jddm_check u_jddm_check (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/joystick_differential_drive_mixer_test.sv
// Self-checking testbench for the joystick differential-drive mixer.
module joystick_differential_drive_mixer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import jddm_pkg::*;

  localparam int CENTER         = 64;
  localparam int FRAC           = 16;
  localparam int SETTLE_CYCLES  = 60;    // pipeline is 48 deep at these parameters
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any beat or register write
  localparam int RANDOM_PER_MIX = 200;   // random samples per idle/stall mix

  // One stick sample as the driver sees it.
  typedef struct packed {
    logic [IN_W-1:0] hor;
    logic [IN_W-1:0] ver;
  } stick_t;

  // One wheel command, same field order as the output beat (high bits first).
  typedef struct packed {
    logic             left_rev;
    logic [CMP_W-1:0] left_cmp;
    logic             right_rev;
    logic [CMP_W-1:0] right_cmp;
  } wheel_cmd_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic                cfg_we_i      = 1'b0;
  logic                cfg_wdata_i   = 1'b0;

  stick_t     stick_queue[$];   // samples waiting to be driven
  wheel_cmd_t wheel_cmds[$];    // predicted commands, oldest first

  logic mirror_model    = 1'b0; // shadow of the mirror register
  int   send_idle_pct   = 0;
  int   recv_stall_pct  = 0;
  int   stall_cycles    = 0;
  int   mismatch_count  = 0;
  int   samples_sent    = 0;
  int   cmds_plain      = 0;
  int   cmds_mirrored   = 0;

  joystick_differential_drive_mixer #(
    .STICK_CENTER(CENTER),
    .FRAC_BITS   (FRAC)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Floor square root by setting result bits from the top down.
  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  // Clamp a Q.FRAC power to 0..1000, drop the fraction, form compare and direction.
  function automatic void power_to_pwm(input longint pq, output logic [CMP_W-1:0] cmp,
                                       output logic rev);
    longint one;
    longint q;
    longint p;
    one = longint'(1) << FRAC;
    q   = pq;
    if (q < 0) q = 0;
    if (q > PWR_MAX * one) q = PWR_MAX * one;
    p = q / one;
    if (p <= PWR_MID) begin
      cmp = CMP_W'(PWR_MAX - 2 * p);
      rev = 1'b0;
    end else begin
      cmp = CMP_W'(2 * p - PWR_MAX);
      rev = 1'b1;
    end
  endfunction

  // Expected wheel command for one stick sample under the given mirror setting.
  function automatic wheel_cmd_t mix_wheels(logic [IN_W-1:0] hor, logic [IN_W-1:0] ver,
                                            logic mirror);
    longint one, h, v, k_rt2, k_035, span, s, dq, xr, xl, dr, dl, base;
    logic [CMP_W-1:0] cmp;
    logic             rev;
    wheel_cmd_t       cmd;
    one   = longint'(1) << FRAC;
    h     = longint'(hor) - CENTER;
    v     = longint'(ver) - CENTER;
    k_rt2 = longint'(root_floor(64'd1 << (2 * FRAC - 1)));  // 1/sqrt2
    k_035 = (35 * one + 50) / 100;
    span  = 2 * CENTER;
    s     = h * h + v * v;
    // inside the full-scale circle the divisor is the span itself (gain < 1)
    if (s <= span * span) dq = span << RAD_FRAC;
    else dq = longint'(root_floor(longint'(s) << (2 * RAD_FRAC)));
    if (dq <= 0) dq = 1;
    xr   = -(h + v) * k_rt2 + h * k_035;
    xl   = (v - h) * k_rt2 + h * k_035;
    dr   = (xr * PWR_MID * (longint'(1) << RAD_FRAC)) / dq;  // truncates toward zero
    dl   = (xl * PWR_MID * (longint'(1) << RAD_FRAC)) / dq;
    base = PWR_MID * one;
    power_to_pwm(mirror ? base + dr : base - dr, cmp, rev);
    cmd.right_cmp = cmp;
    cmd.right_rev = rev;
    power_to_pwm(mirror ? base - dl : base + dl, cmp, rev);
    cmd.left_cmp = cmp;
    cmd.left_rev = rev;
    return cmd;
  endfunction

  // Sender: next beat goes out once the current one is taken (or none is up).
  always @(posedge clk_i or negedge rst_ni) begin
    stick_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (stick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = stick_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_DATA_W - 2 * IN_W){1'b0}}, nxt.ver, nxt.hor};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random backpressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: predict on every input beat, check every output beat.
  always @(posedge clk_i or negedge rst_ni) begin
    wheel_cmd_t got;
    wheel_cmd_t want;
    logic       busy;
    if (!rst_ni) begin
      stall_cycles = 0;
      mirror_model = 1'b0;
    end else begin
      busy = cfg_we_i;
      if (s_axis_tvalid && s_axis_tready) begin
        wheel_cmds.push_back(mix_wheels(s_axis_tdata[IN_W-1:0],
                                        s_axis_tdata[2*IN_W-1:IN_W], mirror_model));
        samples_sent++;
        busy = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        busy = 1'b1;
        got  = wheel_cmd_t'(m_axis_tdata[2*(CMP_W+1)-1:0]);
        if (wheel_cmds.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected output beat 0x%h", $time, m_axis_tdata);
        end else begin
          want = wheel_cmds.pop_front();
          if (got !== want) begin
            mismatch_count++;
            $display("%0t: mismatch exp R %0d/%0b L %0d/%0b, got R %0d/%0b L %0d/%0b",
                     $time, want.right_cmp, want.right_rev, want.left_cmp, want.left_rev,
                     got.right_cmp, got.right_rev, got.left_cmp, got.left_rev);
          end
          if (mirror_model) cmds_mirrored++;
          else cmds_plain++;
        end
      end
      // register takes effect for beats after this edge
      if (cfg_we_i) mirror_model = cfg_wdata_i;
      stall_cycles = busy ? 0 : stall_cycles + 1;
    end
  end

  // Watchdog: no beat or write for too long means the block hung.
  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("joystick_differential_drive_mixer_test failed");
    $finish;
  end

  // Wait until every queued sample has been taken and every command has come back.
  task automatic drain();
    while (stick_queue.size() != 0 || s_axis_tvalid || wheel_cmds.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_mirror(logic val);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly uniform; now and then an axis extreme, the centre or a value next to it.
  function automatic logic [IN_W-1:0] random_axis();
    int pick;
    pick = $urandom_range(15);
    case (pick)
      0: return '0;
      1: return '1;
      2: return IN_W'(CENTER);
      3: return IN_W'(CENTER - 1);
      4: return IN_W'(CENTER + 1);
      default: return IN_W'($urandom_range(2 ** IN_W - 1));
    endcase
  endfunction

  task automatic queue_random(int count);
    stick_t item;
    repeat (count) begin
      item.hor = random_axis();
      item.ver = random_axis();
      stick_queue.push_back(item);
    end
  endtask

  initial begin
    stick_t directed[$];
    int     idle_mix[4];
    int     stall_mix[4];
    // centre, corners, axis ends, one step off centre, alternating bit pattern
    directed = '{
      '{7'd64, 7'd64}, '{7'd0, 7'd0}, '{7'd127, 7'd127}, '{7'd0, 7'd127},
      '{7'd127, 7'd0}, '{7'd64, 7'd0}, '{7'd64, 7'd127}, '{7'd0, 7'd64},
      '{7'd127, 7'd64}, '{7'd65, 7'd64}, '{7'd64, 7'd63}, '{7'h55, 7'h2A}
    };
    idle_mix  = '{0, 47, 0, 37};
    stall_mix = '{0, 0, 47, 37};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed samples at reset mirror setting, then mirrored
    foreach (directed[i]) stick_queue.push_back(directed[i]);
    write_mirror(1'b1);
    foreach (directed[i]) stick_queue.push_back(directed[i]);

    // random samples over four idle/stall mixes, mirror alternating
    for (int ph = 0; ph < 4; ph++) begin
      write_mirror(ph[0]);
      send_idle_pct  = idle_mix[ph];
      recv_stall_pct = stall_mix[ph];
      queue_random(RANDOM_PER_MIX / 2);
      if (ph == 1) drain();  // sender holds off until the pipeline is empty
      queue_random(RANDOM_PER_MIX / 2);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Checked %0d wheel commands from %0d stick samples (%0d plain, %0d mirrored),",
             cmds_plain + cmds_mirrored, samples_sent, cmds_plain, cmds_mirrored);
    $display("under four sender-idle/receiver-stall mixes; %0d mismatches.", mismatch_count);
    if (mismatch_count == 0 && wheel_cmds.size() == 0) begin
      $display("joystick_differential_drive_mixer_test passed");
    end else begin
      $display("joystick_differential_drive_mixer_test failed");
    end
    $finish;
  end

endmodule
